@@ design/stable_counting_sort_assert.svh @@
// ----------------------------------------------------------------------------
// stable_counting_sort assertion macros
// Immediate-implication and next-cycle-implication checks on one clock with
// an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_COUNTING_SORT_ASSERT_SVH
`define STABLE_COUNTING_SORT_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define SCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable_counting_sort: same-cycle check failed");

// check that cons holds in the cycle after ante
`define SCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable_counting_sort: next-cycle check failed");

`endif

@@ design/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the stable counting sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_RANGE_DEF = 256;
    localparam int KEY_W         = 8;
    localparam int PAYLOAD_W     = 16;
    localparam int ITEM_W        = KEY_W + PAYLOAD_W;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload_out;
        logic [KEY_W-1:0]     key_out;
        logic                 last_out;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_LOAD,
        PH_CLEAR,
        PH_COUNT,
        PH_PREFIX,
        PH_SCATTER,
        PH_EMIT
    } t_phase;

    typedef struct packed {
        t_phase phase;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/scs_ctrl.sv @@
// ----------------------------------------------------------------------------
// scs_ctrl
// Phase sequencer: load, clear histogram, count, prefix sum, scatter, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  scs_pkg::t_dp_stat i_stat,
    output scs_pkg::t_dp_cmd  o_cmd
);
    import scs_pkg::*;

    t_phase r_state;
    t_phase n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PH_LOAD:    if (i_stat.done) n_state = PH_CLEAR;
            PH_CLEAR:   if (i_stat.done) n_state = PH_COUNT;
            PH_COUNT:   if (i_stat.done) n_state = PH_PREFIX;
            PH_PREFIX:  if (i_stat.done) n_state = PH_SCATTER;
            PH_SCATTER: if (i_stat.done) n_state = PH_EMIT;
            PH_EMIT:    if (i_stat.done) n_state = PH_LOAD;
            default:    n_state = PH_LOAD;
        endcase
    end

    always_comb begin
        o_cmd.phase = r_state;
    end

endmodule

`default_nettype wire

@@ design/scs_datapath.sv @@
// ----------------------------------------------------------------------------
// scs_datapath
// Item store, key histogram, sorted store, sweep counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_counting_sort_assert.svh"

module scs_datapath #(
    parameter int MAX_ITEMS = scs_pkg::MAX_ITEMS_DEF,
    parameter int KEY_RANGE = scs_pkg::KEY_RANGE_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  scs_pkg::t_dp_cmd           i_cmd,
    output scs_pkg::t_dp_stat          o_stat,
    input  wire                        i_cfg_valid,
    input  wire [scs_pkg::KEY_W-1:0]   i_cfg_data,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  scs_pkg::t_in_item          i_item,
    output logic                       o_valid,
    input  wire                        i_stall,
    output scs_pkg::t_out_item         o_item
);
    import scs_pkg::*;

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int KW   = $clog2(KEY_RANGE);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SPAN = (KEY_RANGE > MAX_ITEMS) ? KEY_RANGE : MAX_ITEMS;
    localparam int SW   = $clog2(SPAN + 1);
    localparam logic [KEY_W-1:0] KEY_CAP =
        (KEY_RANGE - 1 > (2 ** KEY_W) - 1) ? {KEY_W{1'b1}} : KEY_W'(KEY_RANGE - 1);

    // memories
    logic [ITEM_W-1:0] mem_item   [MAX_ITEMS];
    logic [ITEM_W-1:0] mem_sorted [MAX_ITEMS];
    logic [CW-1:0]     mem_hist   [KEY_RANGE];

    logic [KEY_W-1:0]  r_max_key;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_idx;
    logic [CW-1:0]     r_sum;

    logic              r_b_vld;
    logic [KW-1:0]     r_b_addr;
    logic              r_c_vld;
    logic [ITEM_W-1:0] r_c_item;
    logic              r_fw_vld;
    logic [KW-1:0]     r_fw_key;
    logic [CW-1:0]     r_fw_val;

    logic [ITEM_W-1:0] r_item_q;
    logic [CW-1:0]     r_hist_q;
    logic [ITEM_W-1:0] r_sorted_q;
    logic              r_q_vld;
    logic              r_q_last;
    logic              r_o_vld;
    t_out_item         r_o_item;

    logic              ph_load, ph_clear, ph_count, ph_prefix, ph_scatter, ph_emit;
    logic              accept, close, done;
    logic [KEY_W-1:0]  eff_max, key_sat;
    logic [SW-1:0]     n_ext;
    logic              item_issue, hist_issue, emit_issue, q_take;
    logic              c_active;
    logic [KW-1:0]     b_key, c_key;
    logic [CW-1:0]     c_pos;
    logic              hist_we;
    logic [KW-1:0]     hist_wa, hist_ra;
    logic [CW-1:0]     hist_wd;
    logic              hist_re;

    always_comb begin
        ph_load    = (i_cmd.phase == PH_LOAD);
        ph_clear   = (i_cmd.phase == PH_CLEAR);
        ph_count   = (i_cmd.phase == PH_COUNT);
        ph_prefix  = (i_cmd.phase == PH_PREFIX);
        ph_scatter = (i_cmd.phase == PH_SCATTER);
        ph_emit    = (i_cmd.phase == PH_EMIT);
    end

    // load side
    assign o_stall = !ph_load;
    assign accept  = i_valid && ph_load;
    assign eff_max = (r_max_key > KEY_CAP) ? KEY_CAP : r_max_key;
    assign key_sat = (i_item.key > eff_max) ? eff_max : i_item.key;
    assign close   = accept && (i_item.last || (r_count == CW'(MAX_ITEMS - 1)));
    assign n_ext   = SW'(r_count);

    // count / scatter pipeline: item read, histogram read, histogram update
    assign item_issue = (ph_count || ph_scatter) && (r_idx < n_ext);
    assign b_key      = KW'(r_item_q[ITEM_W-1 -: KEY_W]);
    assign c_key      = KW'(r_c_item[ITEM_W-1 -: KEY_W]);
    assign c_active   = r_c_vld && (ph_count || ph_scatter);
    // the previous update lands at the same edge as this bin was read: forward it
    assign c_pos      = (r_fw_vld && (r_fw_key == c_key)) ? r_fw_val : r_hist_q;

    assign hist_issue = ph_prefix && (r_idx < SW'(KEY_RANGE));

    // emit side
    assign q_take     = r_q_vld && (!r_o_vld || !i_stall);
    assign emit_issue = ph_emit && (r_idx < n_ext) && (!r_q_vld || q_take);

    always_comb begin
        done = 1'b0;
        unique case (i_cmd.phase)
            PH_LOAD:    done = close;
            PH_CLEAR:   done = (r_idx == SW'(KEY_RANGE - 1));
            PH_COUNT,
            PH_SCATTER: done = (r_idx == n_ext) && !r_b_vld && !r_c_vld;
            PH_PREFIX:  done = (r_idx == SW'(KEY_RANGE)) && !r_b_vld;
            PH_EMIT:    done = (r_idx == n_ext) && !r_q_vld;
            default:    done = 1'b0;
        endcase
    end

    always_comb begin
        o_stat.done = done;
    end

    // histogram port selection
    always_comb begin
        hist_we = 1'b0;
        hist_wa = r_idx[KW-1:0];
        hist_wd = '0;
        hist_re = 1'b0;
        hist_ra = r_idx[KW-1:0];
        if (ph_clear) begin
            hist_we = 1'b1;
        end else if (ph_prefix) begin
            hist_re = hist_issue;
            hist_we = r_b_vld;
            hist_wa = r_b_addr;
            hist_wd = r_sum;
        end else begin
            hist_re = r_b_vld && (ph_count || ph_scatter);
            hist_ra = b_key;
            hist_we = c_active;
            hist_wa = c_key;
            hist_wd = CW'(c_pos + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_item[r_count[AW-1:0]] <= {key_sat, i_item.payload};
        end
        if (item_issue) begin
            r_item_q <= mem_item[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            mem_hist[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            r_hist_q <= mem_hist[hist_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_active && ph_scatter) begin
            mem_sorted[c_pos[AW-1:0]] <= r_c_item;
        end
        if (emit_issue) begin
            r_sorted_q <= mem_sorted[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_item <= r_item_q;
        r_fw_key <= c_key;
        r_fw_val <= CW'(c_pos + 1'b1);
        r_b_addr <= r_idx[KW-1:0];
        if (q_take) begin
            r_o_item <= '{payload_out: r_sorted_q[PAYLOAD_W-1:0],
                          key_out:     r_sorted_q[ITEM_W-1 -: KEY_W],
                          last_out:    r_q_last};
        end
        if (emit_issue) begin
            r_q_last <= (SW'(r_idx + 1'b1) == n_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_key <= {KEY_W{1'b1}};
            r_count   <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_q_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_key <= i_cfg_data;
            end

            if (accept) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (ph_emit && done) begin
                r_count <= '0;
            end

            if (done) begin
                r_idx <= '0;
            end else if (ph_clear || item_issue || hist_issue || emit_issue) begin
                r_idx <= SW'(r_idx + 1'b1);
            end

            // running exclusive sum of the bins
            if (!ph_prefix) begin
                r_sum <= '0;
            end else if (r_b_vld) begin
                r_sum <= CW'(r_sum + r_hist_q);
            end

            r_b_vld  <= item_issue || hist_issue;
            r_c_vld  <= r_b_vld && (ph_count || ph_scatter);
            r_fw_vld <= c_active;

            if (emit_issue) begin
                r_q_vld <= 1'b1;
            end else if (q_take) begin
                r_q_vld <= 1'b0;
            end

            if (q_take) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_item  = r_o_item;

    `SCS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, ph_load, r_count < CW'(MAX_ITEMS))
    `SCS_ASSERT_IMP(a_sum_matches, i_clk, i_rst_n, ph_prefix && done, r_sum == r_count)
    `SCS_ASSERT_IMP(a_scatter_pos, i_clk, i_rst_n, c_active && ph_scatter, c_pos < r_count)
    `SCS_ASSERT_NXT(a_emit_drains, i_clk, i_rst_n, ph_emit && done, r_count == '0)

endmodule

`default_nettype wire

@@ design/stable_counting_sort.sv @@
// Flow: items load at one per cycle while the block is in its load phase;
// after the closing item the batch passes through the histogram clear, the
// count pass, the prefix sweep and the scatter pass before results are offered.
// Throughput: one result per cycle while emitting and the output is not
// stalled; no new batch is loaded until the emit phase of the last is done.
// Reset: synchronous, clears control state and sets max_key to 255.
// ----------------------------------------------------------------------------
// stable_counting_sort
// Batch sorter: stable counting sort of keyed words with a last mark.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_counting_sort #(
    parameter int MAX_ITEMS = scs_pkg::MAX_ITEMS_DEF,
    parameter int KEY_RANGE = scs_pkg::KEY_RANGE_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [scs_pkg::KEY_W-1:0] i_cfg_data,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  scs_pkg::t_in_item        i_item,
    output logic                     o_valid,
    input  wire                      i_stall,
    output scs_pkg::t_out_item       o_item
);
    import scs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_we;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    scs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scs_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_RANGE (KEY_RANGE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire
